/* hdl/tkh_pkg.sv */
// Shared types and constants for the top-K min-heap tracker.
package tkh_pkg;

   localparam int CAPACITY_DEF   = 1024;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int KEEP_W         = 11;
   localparam int COUNT_W        = 11;
   localparam logic [KEEP_W-1:0] KEEP_RESET = 11'd1024;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_REMOVE,
      OP_DROP,
      OP_TAKE_LAST,
      OP_DOWN_RD,
      OP_DOWN_EV,
      OP_INSERT,
      OP_UP_RD,
      OP_UP_EV,
      OP_RESPOND
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic gt_root;
      logic has_left;
      logic down_swap;
      logic at_root;
      logic up_swap;
   } status_type;

endpackage

/* hdl/top_k_min_heap_tracker_unit.sv */
// Top level of the top-K min-heap tracker: sequencer, heap datapath, checks.
//
//   port group   direction   contents
//   req_*        in          value offered to the store
//   rsp_*        out         accepted, kth_value, stored_count, full_res
//   csr_*        in          keep_count write (K)
//
// Each request is loaded and classified. A drop goes straight to the response;
// an insert appends the value and sifts it up by parent compares; a replace
// removes the root, sifts the last value down by child compares, then does
// the insert's sift-up. Each heap level is a read state then an evaluate state;
// the heap memory has one write and two registered reads. Reset empties the
// heap and sets K to 1024; no clear pass. A new request is taken while a result
// waits; rsp_ready low stalls only the end of the following request.
module top_k_min_heap_tracker_unit #(
   parameter int CAPACITY   = tkh_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = tkh_pkg::DATA_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [DATA_WIDTH-1:0]   req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic signed [DATA_WIDTH-1:0]   rsp_kth_value,
   output logic [tkh_pkg::COUNT_W-1:0]    rsp_stored_count,
   output logic                           rsp_full_res,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tkh_pkg::KEEP_W-1:0]     csr_keep_count
);
   import tkh_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tkh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tkh_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_value),
      .csr_valid        (csr_valid),
      .csr_keep_count   (csr_keep_count),
      .rsp_accepted     (rsp_accepted),
      .rsp_kth_value    (rsp_kth_value),
      .rsp_stored_count (rsp_stored_count),
      .rsp_full_res     (rsp_full_res)
   );

   // one request in flight at a time
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // a value is dropped only by a full heap
   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_full_res)
      else $error("value dropped while heap not full");

   // result register is loaded only into a free or draining slot
   a_respond_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_RESPOND |-> !rsp_valid || rsp_ready)
      else $error("pending result overwritten");

   a_respond_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_RESPOND |=> rsp_valid)
      else $error("result loaded without valid");

endmodule

/* hdl/tkh_datapath.sv */
// Heap memory, index arithmetic, compares, count and response registers.
module tkh_datapath #(
   parameter int CAPACITY   = tkh_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = tkh_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tkh_pkg::cmd_type                    cmd,
   output tkh_pkg::status_type                 status,
   input  logic signed [DATA_WIDTH-1:0]        req_value,
   input  logic                                csr_valid,
   input  logic [tkh_pkg::KEEP_W-1:0]          csr_keep_count,
   output logic                                rsp_accepted,
   output logic signed [DATA_WIDTH-1:0]        rsp_kth_value,
   output logic [tkh_pkg::COUNT_W-1:0]         rsp_stored_count,
   output logic                                rsp_full_res
);
   import tkh_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;
   localparam int KW = (CW > KEEP_W) ? CW : KEEP_W;

   logic signed [DATA_WIDTH-1:0] heap_mem [CAPACITY];

   logic [KEEP_W-1:0]            keep_ff;
   logic [CW-1:0]                count_ff, count_in;
   logic [AW-1:0]                pos_ff, pos_in;
   logic signed [DATA_WIDTH-1:0] val_ff, val_in;
   logic signed [DATA_WIDTH-1:0] mov_ff, mov_in;
   logic signed [DATA_WIDTH-1:0] root_ff, root_in;
   logic                         acc_ff, acc_in;
   logic signed [DATA_WIDTH-1:0] rd_a_ff, rd_b_ff;

   logic                         rsp_acc_ff;
   logic signed [DATA_WIDTH-1:0] rsp_kth_ff;
   logic [COUNT_W-1:0]           rsp_count_ff;
   logic                         rsp_full_ff;

   logic [CW-1:0]                eff_k, cfg_k;
   logic [IW-1:0]                left_i, right_i, count_i;
   logic [AW-1:0]                parent_i;
   logic                         has_right, pick_left;
   logic signed [DATA_WIDTH-1:0] child_val;
   logic [IW-1:0]                child_i;
   logic                         we;
   logic [AW-1:0]                waddr, raddr_a, raddr_b;
   logic signed [DATA_WIDTH-1:0] wdata;

   function automatic logic [CW-1:0] clamp_k(input logic [KEEP_W-1:0] k);
      logic [KW-1:0] kx;
      kx = KW'(k);
      if (kx == '0) begin
         return CW'(1);
      end else if (kx > KW'(CAPACITY)) begin
         return CW'(CAPACITY);
      end else begin
         return CW'(kx);
      end
   endfunction

   assign eff_k = clamp_k(keep_ff);
   assign cfg_k = clamp_k(csr_keep_count);

   assign left_i   = IW'({pos_ff, 1'b1});
   assign right_i  = left_i + IW'(1);
   assign count_i  = IW'(count_ff);
   assign parent_i = (pos_ff - AW'(1)) >> 1;

   assign has_right = right_i < count_i;
   assign pick_left = !has_right || (rd_a_ff < rd_b_ff);
   assign child_val = pick_left ? rd_a_ff : rd_b_ff;
   assign child_i   = pick_left ? left_i : right_i;

   assign status.full      = count_ff >= eff_k;
   assign status.gt_root   = val_ff > root_ff;
   assign status.has_left  = left_i < count_i;
   assign status.down_swap = child_val < mov_ff;
   assign status.at_root   = pos_ff == '0;
   assign status.up_swap   = mov_ff < rd_a_ff;

   always_comb begin
      we      = 1'b0;
      waddr   = pos_ff;
      wdata   = mov_ff;
      raddr_a = '0;
      raddr_b = '0;
      case (cmd.op)
         OP_REMOVE: begin
            raddr_a = AW'(count_ff - CW'(1));
         end
         OP_DOWN_RD: begin
            raddr_a = left_i[AW-1:0];
            raddr_b = right_i[AW-1:0];
            we      = !status.has_left;
         end
         OP_DOWN_EV: begin
            we = 1'b1;
            if (status.down_swap) begin
               wdata = child_val;
            end
         end
         OP_UP_RD: begin
            raddr_a = parent_i;
            we      = status.at_root;
         end
         OP_UP_EV: begin
            we = 1'b1;
            if (status.up_swap) begin
               wdata = rd_a_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      mov_in   = mov_ff;
      acc_in   = acc_ff;
      root_in  = (we && waddr == '0) ? wdata : root_ff;
      if (csr_valid && count_ff > cfg_k) begin
         count_in = cfg_k;
      end
      case (cmd.op)
         OP_LOAD:      val_in = req_value;
         OP_REMOVE: begin
            count_in = count_ff - CW'(1);
            pos_in   = '0;
         end
         OP_DROP:      acc_in = 1'b0;
         OP_TAKE_LAST: mov_in = rd_a_ff;
         OP_DOWN_EV: begin
            if (status.down_swap) begin
               pos_in = child_i[AW-1:0];
            end
         end
         OP_INSERT: begin
            count_in = count_ff + CW'(1);
            pos_in   = AW'(count_ff);
            mov_in   = val_ff;
            acc_in   = 1'b1;
         end
         OP_UP_EV: begin
            if (status.up_swap) begin
               pos_in = parent_i;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff  <= KEEP_RESET;
         count_ff <= '0;
      end else begin
         if (csr_valid) begin
            keep_ff <= csr_keep_count;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      mov_ff  <= mov_in;
      acc_ff  <= acc_in;
      root_ff <= root_in;
      if (cmd.op == OP_RESPOND) begin
         rsp_acc_ff   <= acc_ff;
         rsp_kth_ff   <= root_ff;
         rsp_count_ff <= COUNT_W'(count_ff);
         rsp_full_ff  <= count_ff == eff_k;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         heap_mem[waddr] <= wdata;
      end
      rd_a_ff <= heap_mem[raddr_a];
      rd_b_ff <= heap_mem[raddr_b];
   end

   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_kth_value    = rsp_kth_ff;
   assign rsp_stored_count = rsp_count_ff;
   assign rsp_full_res     = rsp_full_ff;

endmodule

/* hdl/tkh_ctrl.sv */
// Sequencer for insert, replace and drop, plus the response valid register.
module tkh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tkh_pkg::status_type status,
   output tkh_pkg::cmd_type    cmd
);
   import tkh_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_LAST,
      ST_DOWN_RD,
      ST_DOWN_EV,
      ST_INS,
      ST_UP_RD,
      ST_UP_EV,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.full && status.gt_root) begin
               cmd.op   = OP_REMOVE;
               state_in = ST_LAST;
            end else if (status.full) begin
               cmd.op   = OP_DROP;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_INSERT;
               state_in = ST_UP_RD;
            end
         end
         ST_LAST: begin
            cmd.op   = OP_TAKE_LAST;
            state_in = ST_DOWN_RD;
         end
         ST_DOWN_RD: begin
            cmd.op   = OP_DOWN_RD;
            state_in = status.has_left ? ST_DOWN_EV : ST_INS;
         end
         ST_DOWN_EV: begin
            cmd.op   = OP_DOWN_EV;
            state_in = status.down_swap ? ST_DOWN_RD : ST_INS;
         end
         ST_INS: begin
            cmd.op   = OP_INSERT;
            state_in = ST_UP_RD;
         end
         ST_UP_RD: begin
            cmd.op   = OP_UP_RD;
            state_in = status.at_root ? ST_FINISH : ST_UP_EV;
         end
         ST_UP_EV: begin
            cmd.op   = OP_UP_EV;
            state_in = status.up_swap ? ST_UP_RD : ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_RESPOND;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule
